// ----- hw/rtl/dimmer_keypad_controller_unit_assert.svh -----
// Assertion macros for the dimmer keypad controller.
// Used by modules that declare clk and arst_n; no other dependencies.
`ifndef DIMMER_KEYPAD_CONTROLLER_UNIT_ASSERT_SVH
`define DIMMER_KEYPAD_CONTROLLER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define DKC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define DKC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define DKC_ASSERT(lbl, prop, msg)

`define DKC_NEVER(lbl, cond, msg)

`endif

`endif

// ----- hw/rtl/dkc_pkg.sv -----
// Shared constants and types for the dimmer keypad controller.
// No dependencies; imported by the channel interfaces and the top level.
package dkc_pkg;

	localparam int NUM_KEYS   = 3;
	localparam int HOLD_WIDTH = 32;

	localparam int KEY_UP    = 0;
	localparam int KEY_POWER = 1;
	localparam int KEY_DOWN  = 2;

	localparam int BRIGHT_W  = 8;
	localparam int COUNT_W   = 8;
	localparam int THRESH_W  = 24;
	localparam int SAMPLE_W  = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 24;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_DEBOUNCE_SCANS      = 3'd0;
	localparam cfg_idx_t CFG_REPEAT_THRESHOLD    = 3'd1;
	localparam cfg_idx_t CFG_LONG_HOLD_THRESHOLD = 3'd2;
	localparam cfg_idx_t CFG_MIN_BRIGHTNESS      = 3'd3;
	localparam cfg_idx_t CFG_INITIAL_BRIGHTNESS  = 3'd4;
	localparam cfg_idx_t CFG_INITIAL_POWER       = 3'd5;

	localparam logic [COUNT_W-1:0]  RST_DEBOUNCE_SCANS      = 8'd8;
	localparam logic [THRESH_W-1:0] RST_REPEAT_THRESHOLD    = 24'd50000;
	localparam logic [THRESH_W-1:0] RST_LONG_HOLD_THRESHOLD = 24'd7500000;
	localparam logic [BRIGHT_W-1:0] RST_MIN_BRIGHTNESS      = 8'd25;
	localparam logic [BRIGHT_W-1:0] RST_INITIAL_BRIGHTNESS  = 8'd128;
	localparam logic                RST_INITIAL_POWER       = 1'b0;

	localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = '1;
	localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;

	typedef logic [HOLD_WIDTH-1:0] hold_t;

	typedef struct packed {
		logic [NUM_KEYS-1:0] key_levels;
		logic [SAMPLE_W-1:0] timer_sample;
	} scan_t;

	typedef struct packed {
		logic [BRIGHT_W-1:0] brightness;
		logic                power_on;
		logic                up_led;
		logic                down_led;
		logic                boot_pin_low;
		logic                brightness_changed;
		logic                power_changed;
		logic                save_request;
	} result_t;

endpackage

// ----- hw/rtl/dkc_scan_if.sv -----
// Scan request channel: raw key levels and timer sample.
// Depends on dkc_pkg.
interface dkc_scan_if;
	import dkc_pkg::*;

	logic                valid;
	logic                ready;
	logic [NUM_KEYS-1:0] key_levels;
	logic [SAMPLE_W-1:0] timer_sample;

	modport source (output valid, key_levels, timer_sample, input ready);
	modport sink (input valid, key_levels, timer_sample, output ready);
endinterface

// ----- hw/rtl/dkc_result_if.sv -----
// Result channel: dimmer state after each scan.
// Depends on dkc_pkg.
interface dkc_result_if;
	import dkc_pkg::*;

	logic                valid;
	logic                ready;
	logic [BRIGHT_W-1:0] brightness;
	logic                power_on;
	logic                up_led;
	logic                down_led;
	logic                boot_pin_low;
	logic                brightness_changed;
	logic                power_changed;
	logic                save_request;

	modport source (output valid, brightness, power_on, up_led, down_led, boot_pin_low,
		brightness_changed, power_changed, save_request, input ready);
	modport sink (input valid, brightness, power_on, up_led, down_led, boot_pin_low,
		brightness_changed, power_changed, save_request, output ready);
endinterface

// ----- hw/rtl/dkc_cfg_if.sv -----
// Configuration write channel: register index and write data.
// Depends on dkc_pkg.
interface dkc_cfg_if;
	import dkc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/dimmer_keypad_controller_unit.sv -----
// Dimmer keypad controller: button debounce for up, power, down, with hold-to-repeat on up and down.
// Depends on dkc_pkg, the dkc_*_if channel interfaces and the assertion macro header.
//
// One scan request is taken every cycle while the block is not stalled. A request lands in
// an input register, the three keys are resolved in order (up, power, down) by one pass of
// logic that updates the debounce state and loads the result register, from which the result
// is offered. The block stalls only while the result register is full and not taken; the
// configuration port is always ready and its registers take effect on the next scan.
// Writing initial_brightness or initial_power also loads the live brightness or power.
`include "dimmer_keypad_controller_unit_assert.svh"

module dimmer_keypad_controller_unit (
	input logic        clk,
	input logic        arst_n,
	dkc_scan_if.sink   scan,
	dkc_result_if.source result,
	dkc_cfg_if.sink    cfg
);
	import dkc_pkg::*;

	// configuration
	logic [COUNT_W-1:0]  debounce_q;
	logic [THRESH_W-1:0] repeat_thr_q;
	logic [THRESH_W-1:0] long_thr_q;
	logic [BRIGHT_W-1:0] min_bright_q;

	// key state
	logic [NUM_KEYS-1:0] prev_q;
	logic [NUM_KEYS-1:0] qual_q;
	logic [COUNT_W-1:0]  cnt_q [NUM_KEYS];
	hold_t               hold_q [NUM_KEYS];
	logic [BRIGHT_W-1:0] bright_q;
	logic                pwr_q;
	logic [1:0]          led_q;
	logic                boot_q;

	// pipeline
	logic    valid_s1;
	scan_t   scan_s1;
	logic    out_valid_q;
	result_t out_q;

	logic advance;
	logic step;
	logic cfg_wr;

	logic [NUM_KEYS-1:0] prev_d;
	logic [NUM_KEYS-1:0] qual_d;
	logic [COUNT_W-1:0]  cnt_d [NUM_KEYS];
	hold_t               hold_d [NUM_KEYS];
	logic [BRIGHT_W-1:0] bright_d;
	logic                pwr_d;
	logic [1:0]          led_d;
	logic                boot_d;
	logic                bchg_d;
	logic                pchg_d;

	assign advance      = !out_valid_q || result.ready;
	assign step         = valid_s1 && advance;
	assign scan.ready   = !valid_s1 || advance;
	assign cfg.ready    = 1'b1;
	assign cfg_wr       = cfg.valid && cfg.ready;

	assign result.valid              = out_valid_q;
	assign result.brightness         = out_q.brightness;
	assign result.power_on           = out_q.power_on;
	assign result.up_led             = out_q.up_led;
	assign result.down_led           = out_q.down_led;
	assign result.boot_pin_low       = out_q.boot_pin_low;
	assign result.brightness_changed = out_q.brightness_changed;
	assign result.power_changed      = out_q.power_changed;
	assign result.save_request       = out_q.save_request;

	// resolve the keys in order; each sees what the earlier ones changed
	always_comb begin
		logic                lvl;
		logic                qualified;
		logic [HOLD_WIDTH:0] sum;
		hold_t               tot;

		bright_d = bright_q;
		pwr_d    = pwr_q;
		led_d    = led_q;
		boot_d   = boot_q;
		bchg_d   = 1'b0;
		pchg_d   = 1'b0;
		qual_d   = qual_q;
		prev_d   = scan_s1.key_levels;
		for (int i = 0; i < NUM_KEYS; i++) begin
			lvl = scan_s1.key_levels[i];
			cnt_d[i] = (lvl != prev_q[i]) ? '0 : cnt_q[i];
			if (cnt_d[i] != COUNT_MAX) begin
				cnt_d[i] = cnt_d[i] + 1'b1;
			end
			qualified = (cnt_d[i] >= debounce_q);
			sum = {1'b0, hold_q[i]} + (HOLD_WIDTH+1)'(scan_s1.timer_sample);
			tot = sum[HOLD_WIDTH] ? '1 : sum[HOLD_WIDTH-1:0];
			hold_d[i] = hold_q[i];
			if (qualified) begin
				if (!lvl) begin
					hold_d[i] = tot;
					if (pwr_d) begin
						if (tot >= HOLD_WIDTH'(repeat_thr_q)) begin
							if (i == KEY_UP && bright_d != BRIGHT_MAX) begin
								bright_d = bright_d + 1'b1;
								led_d[0] = ~led_d[0];
								bchg_d   = 1'b1;
							end else if (i == KEY_DOWN && bright_d > min_bright_q) begin
								bright_d = bright_d - 1'b1;
								led_d[1] = ~led_d[1];
								bchg_d   = 1'b1;
							end
							hold_d[i] = '0;
						end
					end else if (tot >= HOLD_WIDTH'(long_thr_q)) begin
						if (i == KEY_DOWN) begin
							boot_d = 1'b1;
						end
						hold_d[i] = '0;
					end
				end else begin
					hold_d[i] = '0;
				end
				// qualified release
				if (lvl != qual_q[i]) begin
					qual_d[i] = lvl;
					if (lvl) begin
						if (i == KEY_POWER) begin
							pwr_d  = ~pwr_d;
							pchg_d = 1'b1;
						end
						led_d  = '0;
						boot_d = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q    <= RST_DEBOUNCE_SCANS;
			repeat_thr_q  <= RST_REPEAT_THRESHOLD;
			long_thr_q    <= RST_LONG_HOLD_THRESHOLD;
			min_bright_q  <= RST_MIN_BRIGHTNESS;
			prev_q        <= '1;
			qual_q        <= '1;
			cnt_q         <= '{default: '0};
			hold_q        <= '{default: '0};
			bright_q      <= RST_INITIAL_BRIGHTNESS;
			pwr_q         <= RST_INITIAL_POWER;
			led_q         <= '0;
			boot_q        <= 1'b0;
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (scan.valid && scan.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (step) begin
				prev_q   <= prev_d;
				qual_q   <= qual_d;
				cnt_q    <= cnt_d;
				hold_q   <= hold_d;
				led_q    <= led_d;
				boot_q   <= boot_d;
			end
			// a write of the initial values loads the live state
			if (cfg_wr && cfg.index == CFG_INITIAL_BRIGHTNESS) begin
				bright_q <= cfg.data[BRIGHT_W-1:0];
			end else if (step) begin
				bright_q <= bright_d;
			end
			if (cfg_wr && cfg.index == CFG_INITIAL_POWER) begin
				pwr_q <= cfg.data[0];
			end else if (step) begin
				pwr_q <= pwr_d;
			end
			if (cfg_wr) begin
				case (cfg.index)
					CFG_DEBOUNCE_SCANS: debounce_q <= cfg.data[COUNT_W-1:0];
					CFG_REPEAT_THRESHOLD: repeat_thr_q <= cfg.data[THRESH_W-1:0];
					CFG_LONG_HOLD_THRESHOLD: long_thr_q <= cfg.data[THRESH_W-1:0];
					CFG_MIN_BRIGHTNESS: min_bright_q <= cfg.data[BRIGHT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (scan.valid && scan.ready) begin
			scan_s1.key_levels   <= scan.key_levels;
			scan_s1.timer_sample <= scan.timer_sample;
		end
		if (step) begin
			out_q.brightness         <= bright_d;
			out_q.power_on           <= pwr_d;
			out_q.up_led             <= led_d[0];
			out_q.down_led           <= led_d[1];
			out_q.boot_pin_low       <= boot_d;
			out_q.brightness_changed <= bchg_d;
			out_q.power_changed      <= pchg_d;
			out_q.save_request       <= pchg_d;
		end
	end

	`DKC_ASSERT(a_bright_flag, step && !bchg_d |-> bright_d == bright_q, "brightness moved without flag")
	`DKC_ASSERT(a_stall_holds, valid_s1 && !advance |=> valid_s1, "stalled request dropped")
	`DKC_ASSERT(a_step_result, step |=> result.valid, "processed request produced no result")
	`DKC_NEVER(a_no_overwrite, result.valid && !result.ready && step, "result overwritten while stalled")

endmodule

// ----- bench/testbench.sv -----
// Testbench for dimmer_keypad_controller_unit: scan requests in, one dimmer state out per scan.
// A table of directed scans and register writes runs first, then random key sequences under
// several register settings. Depends on dkc_pkg and the dkc_*_if channel interfaces.
`timescale 1ns / 1ps

module testbench;
	import dkc_pkg::*;

	localparam int LIMIT_CYCLES    = 400000;
	localparam int SETTLE_CYCLES   = 4;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int DIR_ROWS        = 33;

	localparam cfg_idx_t CFG_SPARE_A = 3'd6;
	localparam cfg_idx_t CFG_SPARE_B = 3'd7;

	// active-low key patterns, bit0 up, bit1 power, bit2 down
	localparam logic [NUM_KEYS-1:0] KEYS_IDLE  = 3'b111;
	localparam logic [NUM_KEYS-1:0] KEYS_UP    = 3'b110;
	localparam logic [NUM_KEYS-1:0] KEYS_PWR   = 3'b101;
	localparam logic [NUM_KEYS-1:0] KEYS_DN    = 3'b011;
	localparam logic [NUM_KEYS-1:0] KEYS_UP_DN = 3'b010;
	localparam logic [NUM_KEYS-1:0] KEYS_ALL   = 3'b000;

	typedef enum logic {ROW_SCAN, ROW_WRITE} row_kind_e;

	typedef struct packed {
		row_kind_e             kind;
		logic [NUM_KEYS-1:0]   keys;
		logic [SAMPLE_W-1:0]   sample;
		cfg_idx_t              index;
		logic [CFG_DAT_W-1:0]  data;
		logic                  fixed;
		result_t               want;
	} stim_row_t;

	localparam result_t AT_RESET = '{brightness: RST_INITIAL_BRIGHTNESS, default: 1'b0};
	localparam result_t AT_TOP   = '{brightness: BRIGHT_MAX, power_on: 1'b1, up_led: 1'b1,
		default: 1'b0};
	localparam result_t AT_FLOOR = '{brightness: 8'd0, power_on: 1'b1, default: 1'b0};

	localparam stim_row_t DIRECTED [DIR_ROWS] = '{
		'{ROW_SCAN,  KEYS_IDLE,  16'h0000, CFG_DEBOUNCE_SCANS,      24'h000000, 1'b1, AT_RESET},
		'{ROW_SCAN,  KEYS_ALL,   16'hFFFF, CFG_DEBOUNCE_SCANS,      24'h000000, 1'b1, AT_RESET},
		'{ROW_WRITE, KEYS_IDLE,  16'h0000, CFG_DEBOUNCE_SCANS,      24'h000000, 1'b0, '0},
		'{ROW_WRITE, KEYS_IDLE,  16'h0000, CFG_REPEAT_THRESHOLD,    24'h000000, 1'b0, '0},
		'{ROW_WRITE, KEYS_IDLE,  16'h0000, CFG_INITIAL_POWER,       24'hFFFFFF, 1'b0, '0},
		'{ROW_SCAN,  KEYS_UP,    16'hFFFF, CFG_DEBOUNCE_SCANS,      24'h000000, 1'b0, '0},
		'{ROW_WRITE, KEYS_IDLE,  16'h0000, CFG_INITIAL_BRIGHTNESS,  24'hFFFFFF, 1'b0, '0},
		'{ROW_SCAN,  KEYS_UP,    16'h0000, CFG_DEBOUNCE_SCANS,      24'h000000, 1'b1, AT_TOP},
		'{ROW_WRITE, KEYS_IDLE,  16'h0000, CFG_MIN_BRIGHTNESS,      24'h0000FF, 1'b0, '0},
		'{ROW_SCAN,  KEYS_DN,    16'h8000, CFG_DEBOUNCE_SCANS,      24'h000000, 1'b0, '0},
		'{ROW_WRITE, KEYS_IDLE,  16'h0000, CFG_MIN_BRIGHTNESS,      24'h000000, 1'b0, '0},
		'{ROW_WRITE, KEYS_IDLE,  16'h0000, CFG_INITIAL_BRIGHTNESS,  24'h000000, 1'b0, '0},
		'{ROW_SCAN,  KEYS_DN,    16'h0000, CFG_DEBOUNCE_SCANS,      24'h000000, 1'b1, AT_FLOOR},
		'{ROW_SCAN,  KEYS_UP_DN, 16'h1234, CFG_DEBOUNCE_SCANS,      24'h000000, 1'b0, '0},
		'{ROW_SCAN,  KEYS_PWR,   16'h0001, CFG_DEBOUNCE_SCANS,      24'h000000, 1'b0, '0},
		'{ROW_SCAN,  KEYS_IDLE,  16'hFFFF, CFG_DEBOUNCE_SCANS,      24'h000000, 1'b0, '0},
		'{ROW_WRITE, KEYS_IDLE,  16'h0000, CFG_LONG_HOLD_THRESHOLD, 24'h000000, 1'b0, '0},
		'{ROW_SCAN,  KEYS_DN,    16'h0000, CFG_DEBOUNCE_SCANS,      24'h000000, 1'b0, '0},
		'{ROW_SCAN,  KEYS_IDLE,  16'h0000, CFG_DEBOUNCE_SCANS,      24'h000000, 1'b0, '0},
		'{ROW_WRITE, KEYS_IDLE,  16'h0000, CFG_INITIAL_BRIGHTNESS,  24'h000064, 1'b0, '0},
		'{ROW_SCAN,  KEYS_PWR,   16'h5555, CFG_DEBOUNCE_SCANS,      24'h000000, 1'b0, '0},
		'{ROW_SCAN,  KEYS_DN,    16'hAAAA, CFG_DEBOUNCE_SCANS,      24'h000000, 1'b0, '0},
		'{ROW_WRITE, KEYS_IDLE,  16'h0000, CFG_SPARE_A,             24'hFFFFFF, 1'b0, '0},
		'{ROW_WRITE, KEYS_IDLE,  16'h0000, CFG_SPARE_B,             24'hFFFFFF, 1'b0, '0},
		'{ROW_WRITE, KEYS_IDLE,  16'h0000, CFG_DEBOUNCE_SCANS,      24'hFFFF03, 1'b0, '0},
		'{ROW_WRITE, KEYS_IDLE,  16'h0000, CFG_REPEAT_THRESHOLD,    24'h0186A0, 1'b0, '0},
		'{ROW_SCAN,  KEYS_UP,    16'hFFFF, CFG_DEBOUNCE_SCANS,      24'h000000, 1'b0, '0},
		'{ROW_SCAN,  KEYS_UP,    16'hFFFF, CFG_DEBOUNCE_SCANS,      24'h000000, 1'b0, '0},
		'{ROW_SCAN,  KEYS_UP,    16'hFFFF, CFG_DEBOUNCE_SCANS,      24'h000000, 1'b0, '0},
		'{ROW_SCAN,  KEYS_UP,    16'hFFFF, CFG_DEBOUNCE_SCANS,      24'h000000, 1'b0, '0},
		'{ROW_SCAN,  KEYS_IDLE,  16'h7FFF, CFG_DEBOUNCE_SCANS,      24'h000000, 1'b0, '0},
		'{ROW_SCAN,  KEYS_IDLE,  16'h7FFF, CFG_DEBOUNCE_SCANS,      24'h000000, 1'b0, '0},
		'{ROW_SCAN,  KEYS_IDLE,  16'h7FFF, CFG_DEBOUNCE_SCANS,      24'h000000, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;

	dkc_scan_if   scan_bus ();
	dkc_result_if result_bus ();
	dkc_cfg_if    cfg_bus ();

	dimmer_keypad_controller_unit uut (
		.clk   (clk),
		.arst_n(arst_n),
		.scan  (scan_bus),
		.result(result_bus),
		.cfg   (cfg_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// register mirror
	logic [COUNT_W-1:0]  cfg_debounce;
	logic [THRESH_W-1:0] cfg_repeat;
	logic [THRESH_W-1:0] cfg_long_hold;
	logic [BRIGHT_W-1:0] cfg_min;
	logic [BRIGHT_W-1:0] cfg_init_bright;
	logic                cfg_init_power;

	// dimmer state mirror
	logic [NUM_KEYS-1:0] key_prev;
	logic [NUM_KEYS-1:0] key_qual;
	logic [COUNT_W-1:0]  key_stable [NUM_KEYS];
	hold_t               key_hold [NUM_KEYS];
	logic [BRIGHT_W-1:0] level_now;
	logic                power_now;
	logic [1:0]          led_now;
	logic                boot_now;

	result_t expected_states [$];
	int      mismatches = 0;
	int      cycles = 0;
	int      send_gap_pct;
	int      recv_gap_pct;
	bit      hold_off_ask = 1'b0;
	logic    scan_fixed;
	result_t scan_fixed_want;

	// Resolve one scan the way the block does: up, power, down, each seeing the changes
	// already made by the keys before it.
	function automatic result_t resolve_scan(input logic [NUM_KEYS-1:0] keys,
			input logic [SAMPLE_W-1:0] sample);
		result_t             r;
		logic                lvl;
		logic [HOLD_WIDTH:0] sum;
		logic                stepped;
		logic                toggled;
		stepped = 1'b0;
		toggled = 1'b0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			lvl = keys[k];
			if (lvl != key_prev[k])
				key_stable[k] = '0;
			if (key_stable[k] != COUNT_MAX)
				key_stable[k]++;
			if (key_stable[k] >= cfg_debounce) begin
				if (!lvl) begin
					sum = {1'b0, key_hold[k]} + (HOLD_WIDTH+1)'(sample);
					key_hold[k] = sum[HOLD_WIDTH] ? '1 : sum[HOLD_WIDTH-1:0];
					if (power_now) begin
						if (key_hold[k] >= cfg_repeat) begin
							if (k == KEY_UP && level_now != BRIGHT_MAX) begin
								level_now++;
								led_now[0] = ~led_now[0];
								stepped = 1'b1;
							end else if (k == KEY_DOWN && level_now > cfg_min) begin
								level_now--;
								led_now[1] = ~led_now[1];
								stepped = 1'b1;
							end
							key_hold[k] = '0;
						end
					end else if (key_hold[k] >= cfg_long_hold) begin
						if (k == KEY_DOWN)
							boot_now = 1'b1;
						key_hold[k] = '0;
					end
				end else begin
					key_hold[k] = '0;
				end
				if (lvl != key_qual[k]) begin
					key_qual[k] = lvl;
					if (lvl) begin
						if (k == KEY_POWER) begin
							power_now = ~power_now;
							toggled = 1'b1;
						end
						led_now = '0;
						boot_now = 1'b0;
					end
				end
			end
			key_prev[k] = lvl;
		end
		r.brightness         = level_now;
		r.power_on           = power_now;
		r.up_led             = led_now[0];
		r.down_led           = led_now[1];
		r.boot_pin_low       = boot_now;
		r.brightness_changed = stepped;
		r.power_changed      = toggled;
		r.save_request       = toggled;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : observe
		result_t want;
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready) begin
				case (cfg_bus.index)
					CFG_DEBOUNCE_SCANS:      cfg_debounce = cfg_bus.data[COUNT_W-1:0];
					CFG_REPEAT_THRESHOLD:    cfg_repeat = cfg_bus.data[THRESH_W-1:0];
					CFG_LONG_HOLD_THRESHOLD: cfg_long_hold = cfg_bus.data[THRESH_W-1:0];
					CFG_MIN_BRIGHTNESS:      cfg_min = cfg_bus.data[BRIGHT_W-1:0];
					CFG_INITIAL_BRIGHTNESS: begin
						cfg_init_bright = cfg_bus.data[BRIGHT_W-1:0];
						level_now = cfg_init_bright;
					end
					CFG_INITIAL_POWER: begin
						cfg_init_power = cfg_bus.data[0];
						power_now = cfg_init_power;
					end
					default: ;
				endcase
			end
			if (scan_bus.valid && scan_bus.ready) begin
				want = resolve_scan(scan_bus.key_levels, scan_bus.timer_sample);
				if (scan_fixed)
					want = scan_fixed_want;
				expected_states.push_back(want);
			end
			if (result_bus.valid && result_bus.ready) begin
				if (expected_states.size() == 0) begin
					$error("result with no scan request pending");
					mismatches++;
				end else begin
					want = expected_states.pop_front();
					check_field("brightness", want.brightness, result_bus.brightness);
					check_field("power_on", want.power_on, result_bus.power_on);
					check_field("up_led", want.up_led, result_bus.up_led);
					check_field("down_led", want.down_led, result_bus.down_led);
					check_field("boot_pin_low", want.boot_pin_low, result_bus.boot_pin_low);
					check_field("brightness_changed", want.brightness_changed,
						result_bus.brightness_changed);
					check_field("power_changed", want.power_changed, result_bus.power_changed);
					check_field("save_request", want.save_request, result_bus.save_request);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("** dimmer_keypad_controller_unit: FAILED **");
			$finish;
		end
	end

	// result side: random back-pressure, plus one long hold-off on request
	initial begin : sink_side
		bit held;
		held = 1'b0;
		result_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_ask && !held) begin
				held = 1'b1;
				result_bus.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end
			result_bus.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
		end
	end

	task automatic send_scan(input logic [NUM_KEYS-1:0] keys, input logic [SAMPLE_W-1:0] sample,
			input logic fixed, input result_t want);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			scan_bus.valid <= 1'b0;
			@(negedge clk);
		end
		scan_bus.valid        <= 1'b1;
		scan_bus.key_levels   <= keys;
		scan_bus.timer_sample <= sample;
		scan_fixed            <= fixed;
		scan_fixed_want       <= want;
		do @(posedge clk); while (!scan_bus.ready);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] data);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		do @(posedge clk); while (!cfg_bus.ready);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// hold the scan side until every request has its result, then let the pipe settle
	task automatic drain_all();
		@(negedge clk);
		scan_bus.valid <= 1'b0;
		while (expected_states.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin : stimulus
		stim_row_t           row;
		int                  phase_len;
		int                  sent;
		int                  len;
		int                  roll;
		bit                  paused;
		logic [NUM_KEYS-1:0] keys;
		logic [SAMPLE_W-1:0] sample;
		logic [31:0]         junk;
		logic [COUNT_W-1:0]  deb;
		logic [THRESH_W-1:0] rep;
		logic [THRESH_W-1:0] lng;
		logic [BRIGHT_W-1:0] mn;
		logic [BRIGHT_W-1:0] br;
		logic                pw;

		arst_n                = 1'b0;
		scan_bus.valid        = 1'b0;
		scan_bus.key_levels   = KEYS_IDLE;
		scan_bus.timer_sample = '0;
		cfg_bus.valid         = 1'b0;
		cfg_bus.index         = CFG_DEBOUNCE_SCANS;
		cfg_bus.data          = '0;
		scan_fixed            = 1'b0;
		scan_fixed_want       = '0;

		cfg_debounce    = RST_DEBOUNCE_SCANS;
		cfg_repeat      = RST_REPEAT_THRESHOLD;
		cfg_long_hold   = RST_LONG_HOLD_THRESHOLD;
		cfg_min         = RST_MIN_BRIGHTNESS;
		cfg_init_bright = RST_INITIAL_BRIGHTNESS;
		cfg_init_power  = RST_INITIAL_POWER;
		key_prev        = '1;
		key_qual        = '1;
		for (int k = 0; k < NUM_KEYS; k++) begin
			key_stable[k] = '0;
			key_hold[k]   = '0;
		end
		level_now = RST_INITIAL_BRIGHTNESS;
		power_now = RST_INITIAL_POWER;
		led_now   = '0;
		boot_now  = 1'b0;

		send_gap_pct = 18;
		recv_gap_pct = 59;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			row = DIRECTED[i];
			if (row.kind == ROW_WRITE) begin
				drain_all();
				write_reg(row.index, row.data);
			end else begin
				send_scan(row.keys, row.sample, row.fixed, row.want);
			end
		end

		for (int p = 0; p < 6; p++) begin
			if (p == 2) begin
				send_gap_pct = 59;
				recv_gap_pct = 18;
			end else if (p == 4) begin
				send_gap_pct = 0;
				recv_gap_pct = 0;
			end

			case (p)
				1: begin
					deb = COUNT_MAX;
					rep = 24'd1;
					lng = 24'd1;
					mn  = 8'd0;
					br  = BRIGHT_MAX;
					pw  = 1'b0;
				end
				2: begin
					deb = 8'd0;
					rep = '1;
					lng = '1;
					mn  = BRIGHT_MAX;
					br  = 8'd0;
					pw  = 1'b1;
				end
				default: begin
					deb = COUNT_W'($urandom_range(1, 6));
					rep = THRESH_W'($urandom_range(1, 300000));
					lng = THRESH_W'($urandom_range(1, 600000));
					mn  = BRIGHT_W'($urandom_range(0, 120));
					br  = BRIGHT_W'($urandom_range(0, 255));
					pw  = 1'($urandom_range(0, 1));
				end
			endcase

			drain_all();
			junk = $urandom;
			write_reg(CFG_DEBOUNCE_SCANS, {junk[15:0], deb});
			write_reg(CFG_REPEAT_THRESHOLD, rep);
			write_reg(CFG_LONG_HOLD_THRESHOLD, lng);
			junk = $urandom;
			write_reg(CFG_MIN_BRIGHTNESS, {junk[15:0], mn});
			write_reg(CFG_INITIAL_BRIGHTNESS, {junk[31:16], br});
			junk = $urandom;
			write_reg(CFG_INITIAL_POWER, {junk[22:0], pw});
			if (p == 3)
				write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B, junk[23:0]);

			// keep offering requests while the result side is held off
			if (p == 4)
				hold_off_ask = 1'b1;

			phase_len = (p == 1) ? 300 : 120;
			sent      = 0;
			paused    = 1'b0;
			while (sent < phase_len) begin
				if (p == 5 && !paused && sent >= phase_len / 2) begin
					drain_all();
					paused = 1'b1;
				end
				keys = ($urandom_range(0, 99) < 40) ? KEYS_IDLE : NUM_KEYS'($urandom_range(0, 7));
				roll = $urandom_range(0, 99);
				if (roll < 20)
					len = $urandom_range(1, 3);        // contact bounce
				else if (roll < 25)
					len = 260 + $urandom_range(0, 20); // long enough to pin the stable count
				else
					len = cfg_debounce + $urandom_range(1, 40);
				for (int n = 0; n < len && sent < phase_len; n++) begin
					roll = $urandom_range(0, 99);
					if (roll < 10)
						sample = '0;
					else if (roll < 20)
						sample = '1;
					else
						sample = SAMPLE_W'($urandom_range(0, 65535));
					send_scan(keys, sample, 1'b0, '0);
					sent++;
				end
			end
		end

		drain_all();
		if (mismatches == 0)
			$display("** dimmer_keypad_controller_unit: PASSED **");
		else
			$display("** dimmer_keypad_controller_unit: FAILED **");
		$finish;
	end

endmodule
